/* hw/rtl/pse_pkg.sv */
// Shared types, widths and codes of the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

   // Field widths of the request and response.
   localparam int OP_W     = 3;
   localparam int NUMBER_W = 31;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   // Default operand stack depth.
   localparam int STACK_DEPTH_DEF = 32;

   // Token kinds.
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

   // Status and sticky error codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   typedef logic [DATA_W-1:0]   data_type;
   typedef logic [STATUS_W-1:0] status_type;

endpackage

/* hw/rtl/pse_if.sv */
// Request and response channel interfaces of the postfix stack evaluator.
`timescale 1ns / 1ps

interface pse_req_if
   import pse_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [NUMBER_W-1:0] number;
   logic                last;

   modport source (output valid, output op, output number, output last, input ready);
   modport sink   (input valid, input op, input number, input last, output ready);
endinterface

interface pse_rsp_if
   import pse_pkg::*;
();
   logic              valid;
   logic              ready;
   logic signed [DATA_W-1:0] answer;
   status_type        status;

   modport source (output valid, output answer, output status, input ready);
   modport sink   (input valid, input answer, input status, output ready);
endinterface

/* hw/rtl/postfix_stack_evaluator_core.sv */
// Top level of the postfix stack evaluator: sequencer, operand stack and divider.
//
//   Channel   Direction  Signals                         Moves
//   req_if    in         valid ready op number last      one token per request
//   rsp_if    out        valid ready answer status       one result per last token
//
// A push or an ignored token passes through decode and finish; add, subtract and multiply
// also pass through execute, and a divide adds 32 restoring divider steps, one quotient bit
// each, and the sign fix, unless the divisor is zero. The operand stack is a memory with
// one write port and one registered read port, with the top entry held in a register, so
// an operator needs one memory read.
// A synchronous reset empties the stack and clears the error; no clearing pass is needed.
// The block takes a new request while a result waits in the output register; it stalls
// only when a second result is due before the first has been taken.
`timescale 1ns / 1ps

module postfix_stack_evaluator_core
   import pse_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pse_req_if.sink    req_if,
   pse_rsp_if.source  rsp_if
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(DATA_W);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_DIV,
      S_FIX,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   status_type          err_ff, err_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [NUMBER_W-1:0] number_ff, number_in;
   logic                last_ff, last_in;
   data_type            top_ff, top_in;
   data_type            quo_ff, quo_in;
   data_type            rem_ff, rem_in;
   data_type            divisor_ff, divisor_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   data_type            answer_ff, answer_in;
   status_type          status_ff, status_in;

   // Operand stack below the top entry.
   data_type            stack_mem [STACK_DEPTH];
   data_type            rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;
   logic [SP_W-1:0]     sp_minus1;
   logic [SP_W-1:0]     sp_minus2;

   // Divider step and operand helpers.
   logic [DATA_W:0]     trial;
   data_type            left_mag;
   data_type            right_mag;

   assign sp_minus1 = sp_ff - SP_W'(1);
   assign sp_minus2 = sp_ff - SP_W'(2);
   assign rd_addr   = sp_minus2[ADDR_W-1:0];

   assign left_mag  = rd_data_ff[DATA_W-1] ? (DATA_W'(0) - rd_data_ff) : rd_data_ff;
   assign right_mag = top_ff[DATA_W-1] ? (DATA_W'(0) - top_ff) : top_ff;
   assign trial     = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, divisor_ff};

   // Handshake outputs.
   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.answer = answer_ff;
   assign rsp_if.status = status_ff;

   // Stack memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[sp_minus1[ADDR_W-1:0]] <= top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      op_in        = op_ff;
      number_in    = number_ff;
      last_in      = last_ff;
      top_in       = top_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      answer_in    = answer_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;

      // A waiting result leaves once it is taken.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in     = req_if.op;
               number_in = req_if.number;
               last_in   = req_if.last;
               state_in  = S_DECODE;
            end
         end

         // Pushes complete here; operators check depth and start the read.
         S_DECODE: begin
            state_in = S_FINISH;
            if (err_ff == ST_OK) begin
               if (op_ff == OP_PUSH) begin
                  if (sp_ff == SP_W'(STACK_DEPTH)) begin
                     err_in = ST_OVER;
                  end else begin
                     mem_we = (sp_ff != '0);
                     top_in = {1'b0, number_ff};
                     sp_in  = sp_ff + SP_W'(1);
                  end
               end else if (op_ff == OP_ADD || op_ff == OP_SUB || op_ff == OP_MUL ||
                            op_ff == OP_DIV) begin
                  if (sp_ff < SP_W'(2)) begin
                     err_in = ST_UNDER;
                  end else begin
                     state_in = S_EXEC;
                  end
               end
            end
         end

         // Left operand is now in the read register, right operand in the top register.
         S_EXEC: begin
            state_in = S_FINISH;
            unique case (op_ff)
               OP_ADD: begin
                  top_in = rd_data_ff + top_ff;
                  sp_in  = sp_minus1;
               end
               OP_SUB: begin
                  top_in = rd_data_ff - top_ff;
                  sp_in  = sp_minus1;
               end
               OP_MUL: begin
                  top_in = rd_data_ff * top_ff;
                  sp_in  = sp_minus1;
               end
               default: begin
                  if (top_ff == '0) begin
                     err_in = ST_DIV0;
                  end else begin
                     quo_in     = left_mag;
                     rem_in     = '0;
                     divisor_in = right_mag;
                     neg_in     = rd_data_ff[DATA_W-1] ^ top_ff[DATA_W-1];
                     cnt_in     = '0;
                     state_in   = S_DIV;
                  end
               end
            endcase
         end

         // One restoring division step per cycle, quotient bits shift in at the bottom.
         S_DIV: begin
            if (!trial[DATA_W]) begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               state_in = S_FIX;
            end
         end

         // Apply the quotient sign and replace both operands with the result.
         S_FIX: begin
            top_in   = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
            sp_in    = sp_minus1;
            state_in = S_FINISH;
         end

         // On the last token, load the result and clear the expression state.
         S_FINISH: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  status_in = err_ff;
                  answer_in = '0;
               end else if (sp_ff == '0) begin
                  status_in = ST_EMPTY;
                  answer_in = '0;
               end else begin
                  status_in = ST_OK;
                  answer_in = top_ff;
               end
               sp_in    = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      number_ff    <= number_in;
      last_ff      <= last_in;
      top_ff       <= top_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      answer_ff    <= answer_in;
      status_ff    <= status_in;
   end

endmodule

/* hw/rtl/pse_checker.sv */
// Port-level checks of the postfix stack evaluator, bound to the top level.
`timescale 1ns / 1ps

module pse_checker
   import pse_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input data_type   rsp_answer,
   input status_type rsp_status
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer) && $stable(rsp_status))
      else $error("response changed while stalled");

   // A failed expression reports a zero answer.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_answer == '0)
      else $error("non-zero answer with error status");

   // The engine works on one request at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // No result is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A result cannot appear in the cycle right after a request is taken.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_answer (rsp_if.answer),
   .rsp_status (rsp_if.status)
);
